[hdl/spq_pkg.sv]
// Shared types, field widths and codes for the sorted priority queue.
package spq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 64;

	localparam int PID_W     = 16;
	localparam int PRIO_W    = 8;
	localparam int RUN_W     = 9;
	localparam int OCC_W     = 7;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 3;

	localparam logic [PRIO_W-1:0] CEILING_RESET = 8'd200;

	// Command codes carried on s_tuser
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_AGE    = 2'd2;

	// Result status codes carried on m_tuser
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// One stored entry; pid sits in the lowest bits
	typedef struct packed {
		logic [RUN_W-1:0]  run_time;
		logic [PRIO_W-1:0] prio;
		logic [PID_W-1:0]  pid;
	} entry_t;

	// One pending result before it reaches the output register
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                pop_valid;
		entry_t              ent;
	} result_t;

endpackage

[hdl/sorted_priority_queue.sv]
// Sorted priority queue: ring memory of entries driven by a read-modify-write sequencer.
//
// Entries live in a single synchronous memory (one write, one registered read per cycle)
// used as a ring: the head pointer marks the highest-priority entry, and logical index i
// sits at (head + i) mod QUEUE_DEPTH. One command is worked at a time. A pop reads the
// head, captures it and hands it off to the result register. An age sweeps every stored
// entry, and on an empty queue goes straight to the result. An insert walks from the
// tail toward the head, moving each lower-priority entry up by one slot, one entry per
// cycle through the memory port, until the new entry stops below a kept entry or lands
// at the head; on an empty queue it is written at once. Dropped inserts, empty pops and
// the unused code go straight to the result. The single memory port sets the pace of
// the insert and age walks. A new command may be accepted while the previous result
// still waits on the master side. The priority ceiling is written through the cfg
// channel, which is always ready.
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration: priority ceiling
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [spq_pkg::PRIO_W-1:0]      cfg_data,
	// Command items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tdata: item_pid[15:0], item_priority[23:16], item_run_time[32:24], zero pad
	input  logic [spq_pkg::IN_DATA_W-1:0]   s_tdata,
	// tuser: command[1:0]
	input  logic [spq_pkg::CMD_W-1:0]       s_tuser,
	// Result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata: out_pid[15:0], out_priority[23:16], out_run_time[32:24], occupancy[39:33]
	output logic [spq_pkg::OUT_DATA_W-1:0]  m_tdata,
	// tuser: status[1:0], pop_valid[2]
	output logic [spq_pkg::OUT_USER_W-1:0]  m_tuser
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_A = (AW+1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_INS_HEAD,
		ST_POP,
		ST_AGE,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic [AW-1:0]             head_q;
	logic [AW-1:0]             rd_idx_q;
	spq_pkg::entry_t           new_q;
	spq_pkg::result_t          res_q;
	logic [spq_pkg::PRIO_W-1:0] ceil_q;
	logic                      m_tvalid_q;
	logic [spq_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [spq_pkg::OUT_USER_W-1:0] m_tuser_q;

	spq_pkg::entry_t mem [QUEUE_DEPTH];
	spq_pkg::entry_t rd_q;

	spq_pkg::entry_t in_entry;
	spq_pkg::entry_t wr_data;
	spq_pkg::entry_t aged;
	logic            s_accept;
	logic            out_free;
	logic            load_out;
	logic            rd_en;
	logic            wr_en;
	logic [AW-1:0]   rd_log;
	logic [AW-1:0]   wr_log;
	logic [AW-1:0]   last_idx;
	logic            is_full;
	logic            is_empty;
	logic            move_up;
	logic [spq_pkg::STATUS_W-1:0] acc_status;

	// Map a logical queue index to its ring address
	function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] hd, input logic [AW-1:0] lg);
		logic [AW:0] s;
		s = {1'b0, hd} + {1'b0, lg};
		if (s >= DEPTH_A) begin
			s = s - DEPTH_A;
		end
		return s[AW-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign load_out  = (state_q == ST_DONE) && out_free;
	assign in_entry  = spq_pkg::entry_t'(s_tdata[$bits(spq_pkg::entry_t)-1:0]);
	assign last_idx  = AW'(count_q - CW'(1));
	assign is_full   = (count_q == DEPTH_C);
	assign is_empty  = (count_q == '0);
	assign move_up   = (rd_q.prio < new_q.prio);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Saturating age of the entry just read
	always_comb begin
		aged = rd_q;
		if (rd_q.prio < ceil_q) begin
			aged.prio = rd_q.prio + 8'd1;
		end
	end

	// Status of the command being accepted
	always_comb begin
		acc_status = spq_pkg::STATUS_OK;
		if (s_tuser == spq_pkg::CMD_INSERT && is_full) begin
			acc_status = spq_pkg::STATUS_FULL;
		end else if (s_tuser == spq_pkg::CMD_POP && is_empty) begin
			acc_status = spq_pkg::STATUS_EMPTY;
		end
	end

	// Memory port control for the current step
	always_comb begin
		rd_en   = 1'b0;
		rd_log  = '0;
		wr_en   = 1'b0;
		wr_log  = '0;
		wr_data = new_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					unique case (s_tuser)
						spq_pkg::CMD_INSERT: begin
							if (is_empty) begin
								wr_en   = 1'b1;
								wr_data = in_entry;
							end else if (!is_full) begin
								rd_en  = 1'b1;
								rd_log = last_idx;
							end
						end
						spq_pkg::CMD_POP, spq_pkg::CMD_AGE: begin
							rd_en = !is_empty;
						end
						default: begin
						end
					endcase
				end
			end
			ST_INS: begin
				wr_en  = 1'b1;
				wr_log = rd_idx_q + AW'(1);
				if (move_up) begin
					wr_data = rd_q;
					if (rd_idx_q != '0) begin
						rd_en  = 1'b1;
						rd_log = rd_idx_q - AW'(1);
					end
				end
			end
			ST_INS_HEAD: begin
				wr_en = 1'b1;
			end
			ST_AGE: begin
				wr_en   = 1'b1;
				wr_log  = rd_idx_q;
				wr_data = aged;
				if (rd_idx_q != last_idx) begin
					rd_en  = 1'b1;
					rd_log = rd_idx_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Entry memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[to_phys(head_q, wr_log)] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[to_phys(head_q, rd_log)];
		end
	end

	// Sequencer, queue bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			head_q     <= '0;
			rd_idx_q   <= '0;
			new_q      <= '0;
			res_q      <= '0;
			ceil_q     <= spq_pkg::CEILING_RESET;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ceil_q <= cfg_data;
			end
			// Hand the result over once the output register is free, else drop a taken one
			if (load_out) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {spq_pkg::OCC_W'(count_q), res_q.ent};
				m_tuser_q  <= {res_q.pop_valid, res_q.status};
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						new_q <= in_entry;
						res_q <= '{status: acc_status, pop_valid: 1'b0, ent: '0};
						unique case (s_tuser)
							spq_pkg::CMD_INSERT: begin
								if (!is_full && !is_empty) begin
									rd_idx_q <= last_idx;
									state_q  <= ST_INS;
								end else begin
									if (!is_full) begin
										count_q <= count_q + CW'(1);
									end
									state_q <= ST_DONE;
								end
							end
							spq_pkg::CMD_POP: begin
								state_q <= is_empty ? ST_DONE : ST_POP;
							end
							spq_pkg::CMD_AGE: begin
								rd_idx_q <= '0;
								state_q  <= is_empty ? ST_DONE : ST_AGE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_INS: begin
					if (move_up) begin
						if (rd_idx_q == '0) begin
							state_q <= ST_INS_HEAD;
						end else begin
							rd_idx_q <= rd_idx_q - AW'(1);
						end
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_INS_HEAD: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_DONE;
				end
				ST_POP: begin
					res_q   <= '{status: spq_pkg::STATUS_OK, pop_valid: 1'b1, ent: rd_q};
					head_q  <= to_phys(head_q, AW'(1));
					count_q <= count_q - CW'(1);
					state_q <= ST_DONE;
				end
				ST_AGE: begin
					if (rd_idx_q == last_idx) begin
						state_q <= ST_DONE;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				ST_DONE: begin
					// Return to idle as the result moves into the output register
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/spq_checker.sv]
// Port-level checks for the sorted priority queue and their bind to the top level.
module spq_checker #(
	parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [spq_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [spq_pkg::OUT_USER_W-1:0]  m_tuser
);

	localparam logic [spq_pkg::OCC_W-1:0] DEPTH_OCC = spq_pkg::OCC_W'(QUEUE_DEPTH);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A popped entry always comes with an ok status
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == spq_pkg::STATUS_OK)
		else $error("popped entry with error status");

	// Without a popped entry the entry fields are zero
	a_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> m_tdata[32:0] == '0)
		else $error("entry fields set without a pop");

	// A dropped insert reports a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == spq_pkg::STATUS_FULL |-> m_tdata[39:33] == DEPTH_OCC)
		else $error("full status with occupancy below depth");

	// An empty pop reports an empty queue
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == spq_pkg::STATUS_EMPTY |-> m_tdata[39:33] == '0)
		else $error("empty status with nonzero occupancy");

endmodule

bind sorted_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[verif/tb.sv]
// Self-checking testbench for the sorted priority queue: table-driven and random commands.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_SLOTS = spq_pkg::DEFAULT_QUEUE_DEPTH;
	localparam int PHASE_COMMANDS = 175;
	localparam int TAIL_CYCLES = 80;
	localparam logic [spq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	// One reply of the queue, fields in the order of the result description
	typedef struct packed {
		logic [spq_pkg::STATUS_W-1:0] status;
		logic                         pop_valid;
		logic [spq_pkg::PID_W-1:0]    pid;
		logic [spq_pkg::PRIO_W-1:0]   prio;
		logic [spq_pkg::RUN_W-1:0]    run_time;
		logic [spq_pkg::OCC_W-1:0]    occupancy;
	} queue_reply_t;

	// One command; reply is used only where typed is set
	typedef struct packed {
		logic [spq_pkg::CMD_W-1:0]  cmd;
		logic [spq_pkg::PID_W-1:0]  pid;
		logic [spq_pkg::PRIO_W-1:0] prio;
		logic [spq_pkg::RUN_W-1:0]  run_time;
		logic                       typed;
		queue_reply_t               reply;
	} command_row_t;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} command_mix_t;
	typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_BUSY} sink_mode_t;

	localparam queue_reply_t NO_REPLY = '0;
	localparam int DIRECTED_ROWS = 25;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [spq_pkg::PRIO_W-1:0]        cfg_data = '0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [spq_pkg::IN_DATA_W-1:0]     s_tdata = '0;
	logic [spq_pkg::CMD_W-1:0]         s_tuser = spq_pkg::CMD_INSERT;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [spq_pkg::OUT_DATA_W-1:0]    m_tdata;
	logic [spq_pkg::OUT_USER_W-1:0]    m_tuser;

	// Shadow queue state
	spq_pkg::entry_t            ready_list[$];
	logic [spq_pkg::PRIO_W-1:0] aging_ceiling = spq_pkg::CEILING_RESET;

	command_row_t  issued_rows[$];
	queue_reply_t  owed_replies[$];
	int            commands_issued = 0;
	int            replies_taken = 0;
	int            mismatch_count = 0;
	int            burst_left = 0;

	command_row_t directed_plan [DIRECTED_ROWS] = '{
		// empty queue: pop is flagged, age and the unused code change nothing
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b1,
			'{spq_pkg::STATUS_EMPTY, 1'b0, 16'h0, 8'h0, 9'h0, 7'd0}},
		'{spq_pkg::CMD_AGE,    16'h0000, 8'h00, 9'h000, 1'b1,
			'{spq_pkg::STATUS_OK, 1'b0, 16'h0, 8'h0, 9'h0, 7'd0}},
		'{CMD_UNUSED,          16'hFFFF, 8'hFF, 9'h1FF, 1'b1,
			'{spq_pkg::STATUS_OK, 1'b0, 16'h0, 8'h0, 9'h0, 7'd0}},
		// field extremes
		'{spq_pkg::CMD_INSERT, 16'hFFFF, 8'hFF, 9'h1FF, 1'b1,
			'{spq_pkg::STATUS_OK, 1'b0, 16'h0, 8'h0, 9'h0, 7'd1}},
		'{spq_pkg::CMD_INSERT, 16'h0000, 8'h00, 9'h000, 1'b1,
			'{spq_pkg::STATUS_OK, 1'b0, 16'h0, 8'h0, 9'h0, 7'd2}},
		// equal priorities keep arrival order, around the reset ceiling
		'{spq_pkg::CMD_INSERT, 16'h1234, 8'd199, 9'h064, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_INSERT, 16'h2222, 8'd200, 9'h007, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_INSERT, 16'h3333, 8'd200, 9'h008, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_INSERT, 16'h4444, 8'd199, 9'h0AA, 1'b0, NO_REPLY},
		// age twice: entries at or above the ceiling hold, the rest climb
		'{spq_pkg::CMD_AGE,    16'h5A5A, 8'h5A, 9'h15A, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_AGE,    16'hA5A5, 8'hA5, 9'h0A5, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b1,
			'{spq_pkg::STATUS_OK, 1'b1, 16'hFFFF, 8'hFF, 9'h1FF, 7'd5}},
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b0, NO_REPLY},
		// tie at the tail with an aged entry
		'{spq_pkg::CMD_INSERT, 16'hAAAA, 8'd2,   9'h09B, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b1,
			'{spq_pkg::STATUS_EMPTY, 1'b0, 16'h0, 8'h0, 9'h0, 7'd0}},
		// higher priority overtakes, unused code leaves the queue alone
		'{spq_pkg::CMD_INSERT, 16'h5555, 8'h80, 9'h100, 1'b1,
			'{spq_pkg::STATUS_OK, 1'b0, 16'h0, 8'h0, 9'h0, 7'd1}},
		'{spq_pkg::CMD_INSERT, 16'h0001, 8'h81, 9'h0FF, 1'b0, NO_REPLY},
		'{CMD_UNUSED,          16'h0F0F, 8'h33, 9'h055, 1'b1,
			'{spq_pkg::STATUS_OK, 1'b0, 16'h0, 8'h0, 9'h0, 7'd2}},
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b0, NO_REPLY},
		'{spq_pkg::CMD_POP,    16'h0000, 8'h00, 9'h000, 1'b0, NO_REPLY}
	};

	sorted_priority_queue #(
		.QUEUE_DEPTH(QUEUE_SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one command to the shadow queue and return the reply it causes
	function automatic queue_reply_t apply_command(input logic [spq_pkg::CMD_W-1:0] cmd,
			input spq_pkg::entry_t ent);
		queue_reply_t    reply;
		spq_pkg::entry_t slot_ent;
		int              slot;
		int              i;
		reply = '0;
		case (cmd)
			spq_pkg::CMD_INSERT: begin
				if (ready_list.size() >= QUEUE_SLOTS) begin
					reply.status = spq_pkg::STATUS_FULL;
				end else begin
					// land before the first entry of strictly lower priority
					slot = ready_list.size();
					for (i = ready_list.size() - 1; i >= 0; i--) begin
						if (ready_list[i].prio < ent.prio)
							slot = i;
					end
					ready_list.insert(slot, ent);
				end
			end
			spq_pkg::CMD_POP: begin
				if (ready_list.size() == 0) begin
					reply.status = spq_pkg::STATUS_EMPTY;
				end else begin
					slot_ent = ready_list.pop_front();
					reply.pop_valid = 1'b1;
					reply.pid = slot_ent.pid;
					reply.prio = slot_ent.prio;
					reply.run_time = slot_ent.run_time;
				end
			end
			spq_pkg::CMD_AGE: begin
				for (i = 0; i < ready_list.size(); i++) begin
					slot_ent = ready_list[i];
					if (slot_ent.prio < aging_ceiling) begin
						slot_ent.prio = slot_ent.prio + 8'd1;
						ready_list[i] = slot_ent;
					end
				end
			end
			default: begin
			end
		endcase
		reply.occupancy = spq_pkg::OCC_W'(ready_list.size());
		return reply;
	endfunction

	task automatic note_mismatch(input string field, input int unsigned want,
			input int unsigned got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
	endtask

	// Compare one delivered reply against the oldest owed one
	task automatic check_reply(input queue_reply_t got);
		queue_reply_t want;
		if (owed_replies.size() == 0) begin
			note_mismatch("unrequested reply", 32'd0, 32'(got));
			return;
		end
		want = owed_replies.pop_front();
		if (got.status != want.status)
			note_mismatch("status", 32'(want.status), 32'(got.status));
		if (got.pop_valid != want.pop_valid)
			note_mismatch("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
		if (got.pid != want.pid)
			note_mismatch("out_pid", 32'(want.pid), 32'(got.pid));
		if (got.prio != want.prio)
			note_mismatch("out_priority", 32'(want.prio), 32'(got.prio));
		if (got.run_time != want.run_time)
			note_mismatch("out_run_time", 32'(want.run_time), 32'(got.run_time));
		if (got.occupancy != want.occupancy)
			note_mismatch("occupancy", 32'(want.occupancy), 32'(got.occupancy));
	endtask

	// Track config writes, accepted commands and delivered replies
	always @(posedge clk) begin : scoreboard
		command_row_t row;
		queue_reply_t reply;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				aging_ceiling = cfg_data;
			if (s_tvalid && s_tready) begin
				row = issued_rows.pop_front();
				reply = apply_command(s_tuser, spq_pkg::entry_t'(s_tdata[32:0]));
				owed_replies.push_back(row.typed ? row.reply : reply);
			end
			if (m_tvalid && m_tready) begin
				check_reply('{m_tuser[1:0], m_tuser[2], m_tdata[15:0], m_tdata[23:16],
					m_tdata[32:24], m_tdata[39:33]});
				replies_taken++;
			end
		end
	end

	// Receiver stalls in stretches of random mood
	initial begin : reply_sink
		sink_mode_t mode;
		int         span;
		forever begin
			mode = sink_mode_t'($urandom_range(0, 3));
			span = $urandom_range(4, 60);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					SINK_OPEN: m_tready <= 1'b1;
					SINK_COIN: m_tready <= 1'($urandom_range(0, 1));
					SINK_SLOW: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Drive one command, opening a new burst after a random gap when one runs out
	task automatic issue_command(input command_row_t row);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		issued_rows.push_back(row);
		s_tvalid <= 1'b1;
		s_tuser <= row.cmd;
		s_tdata <= {7'd0, row.run_time, row.prio, row.pid};
		do @(posedge clk); while (!s_tready);
		commands_issued++;
	endtask

	// Hold off until every issued command has delivered its reply
	task automatic settle_queue();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (replies_taken != commands_issued) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ceiling(input logic [spq_pkg::PRIO_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Build one random command; priorities cluster at the ceiling and the extremes
	function automatic command_row_t random_command(input command_mix_t mix,
			input logic [spq_pkg::PRIO_W-1:0] ceiling);
		command_row_t row;
		int unsigned  roll;
		int unsigned  insert_top;
		int unsigned  pop_top;
		int           near;
		row = '0;
		case (mix)
			MIX_FILL: begin
				insert_top = 80;
				pop_top = 86;
			end
			MIX_DRAIN: begin
				insert_top = 12;
				pop_top = 84;
			end
			default: begin
				insert_top = 45;
				pop_top = 85;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < insert_top)
			row.cmd = spq_pkg::CMD_INSERT;
		else if (roll < pop_top)
			row.cmd = spq_pkg::CMD_POP;
		else if (roll < 98)
			row.cmd = spq_pkg::CMD_AGE;
		else
			row.cmd = CMD_UNUSED;
		row.pid = spq_pkg::PID_W'($urandom_range(0, 65535));
		row.run_time = spq_pkg::RUN_W'($urandom_range(0, 511));
		roll = $urandom_range(0, 9);
		if (roll < 4) begin
			near = int'(ceiling) + int'($urandom_range(0, 3)) - 2;
			if (near < 0)
				near = 0;
			if (near > 255)
				near = 255;
			row.prio = spq_pkg::PRIO_W'(near);
		end else if (roll < 6) begin
			row.prio = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		end else begin
			row.prio = spq_pkg::PRIO_W'($urandom_range(0, 255));
		end
		return row;
	endfunction

	initial begin : stimulus
		logic [spq_pkg::PRIO_W-1:0] ceiling_plan [6];
		command_mix_t               mix;
		int                         phase;
		int                         left;
		int                         seg_left;
		int                         k;
		ceiling_plan[0] = 8'd0;
		ceiling_plan[1] = 8'd255;
		ceiling_plan[2] = 8'd1;
		ceiling_plan[3] = spq_pkg::PRIO_W'($urandom_range(2, 253));
		ceiling_plan[4] = 8'd254;
		ceiling_plan[5] = spq_pkg::CEILING_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset ceiling
		for (k = 0; k < DIRECTED_ROWS; k++)
			issue_command(directed_plan[k]);

		// Random phases, one ceiling each, written while the queue is quiet
		for (phase = 0; phase < 6; phase++) begin
			settle_queue();
			write_ceiling(ceiling_plan[phase]);
			left = PHASE_COMMANDS;
			while (left > 0) begin
				mix = command_mix_t'($urandom_range(0, 2));
				seg_left = $urandom_range(20, 120);
				while (seg_left > 0 && left > 0) begin
					issue_command(random_command(mix, ceiling_plan[phase]));
					seg_left--;
					left--;
				end
			end
		end

		settle_queue();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && owed_replies.size() == 0) begin
			$display("** sorted_priority_queue: PASSED **");
		end else begin
			$display("** sorted_priority_queue: FAILED **");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin : watchdog
		#10ms;
		$display("** sorted_priority_queue: FAILED **");
		$finish;
	end

endmodule

[files.f]
hdl/spq_pkg.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
verif/tb.sv
